[rtl/timecode_arithmetic_unit_top_macros.svh]
// ----------------------------------------------------------------------------
// Timecode arithmetic unit assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef TIMECODE_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define TIMECODE_ARITHMETIC_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define TCAU_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCAU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tcau_pkg.sv]
// ----------------------------------------------------------------------------
// Timecode arithmetic unit package
// Transaction types, pipeline stage type and shared constants.
// ----------------------------------------------------------------------------
package tcau_pkg;

   localparam int HOUR_WRAP_DEFAULT = 100;
   localparam int BASE_60           = 60;
   localparam int RATE_RESET        = 25;
   localparam int SEC_W             = 20;
   localparam int QUO_W             = 13;
   localparam int TOTAL_W           = 25;
   // largest seconds count one input timecode can express (all fields at max)
   localparam int SEC_IN_MAX        = (127 * 60 + 63) * 60 + 63;

   localparam logic CMD_SUM      = 1'b0;
   localparam logic CMD_DURATION = 1'b1;

   localparam int REG_FRAME_RATE = 0;

   typedef struct packed {
      logic       command;
      logic [6:0] first_hours;
      logic [5:0] first_minutes;
      logic [5:0] first_seconds;
      logic [5:0] first_frames;
      logic [6:0] second_hours;
      logic [5:0] second_minutes;
      logic [5:0] second_seconds;
      logic [5:0] second_frames;
   } req_type;

   typedef struct packed {
      logic [6:0]         result_hours;
      logic [5:0]         result_minutes;
      logic [5:0]         result_seconds;
      logic [5:0]         result_frames;
      logic [TOTAL_W-1:0] result_total;
      logic               underflow;
   } rsp_type;

   typedef struct packed {
      logic [SEC_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic [SEC_W-1:0] tot_sec;
      logic [5:0]       sec;
      logic [5:0]       frm;
      logic [5:0]       rate;
      logic             under;
   } pipe_type;

   // divisor of chain cell i: wrap reduction, then seconds/60, then minutes/60
   function automatic int unsigned cell_div(int i, int k1, int k2, int nc,
                                            int unsigned ws);
      int unsigned d;
      if (i < k1) begin
         d = ws << (k1 - 1 - i);
      end else if (i < k1 + k2) begin
         d = BASE_60 << (k1 + k2 - 1 - i);
      end else begin
         d = BASE_60 << (nc - 1 - i);
      end
      return d;
   endfunction

endpackage

[rtl/timecode_arithmetic_unit_top.sv]
// ----------------------------------------------------------------------------
// Timecode arithmetic unit
// Non-drop-frame timecode sum and duration at a programmable frame rate.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  tcau_pkg::req_type
//  rsp       out        rsp_valid/rsp_stall  tcau_pkg::rsp_type
//  csr       in/out     psel/penable/pready  frame_rate at byte address 0
//
//  One transaction per cycle while rsp_stall is low. A result passes the
//  front end, the row of divide cells (K1 wrap-reduction cells, K2 cells
//  for seconds / 60, K3 for minutes / 60) and the output stage.
//  Reset is synchronous and empties every stage; frame_rate returns to 25.
//  Each stage holds while the one after it is full and stalled, so bubbles
//  still fill and new requests enter while a result waits on rsp_stall.
// ----------------------------------------------------------------------------
module timecode_arithmetic_unit_top #(
   parameter int HOUR_WRAP = tcau_pkg::HOUR_WRAP_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tcau_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tcau_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int SW = tcau_pkg::SEC_W;
   // seconds in one wrap period
   localparam int unsigned WS = HOUR_WRAP * 3600;
   // cells per phase: quotient bits each divide can produce
   localparam int K1 = $clog2((2 * tcau_pkg::SEC_IN_MAX + 1) / WS + 1);
   localparam int K2 = $clog2(HOUR_WRAP * tcau_pkg::BASE_60);
   localparam int K3 = $clog2(HOUR_WRAP);
   localparam int NC = K1 + K2 + K3;

   // ---------------------------------------------------------------- csr
   logic [5:0] rate_ff;
   logic       reg_hit;

   assign pready  = 1'b1;
   assign reg_hit = paddr == 3'(4 * tcau_pkg::REG_FRAME_RATE);

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= 6'(tcau_pkg::RATE_RESET);
      end else if (psel && penable && pwrite && reg_hit) begin
         rate_ff <= pwdata[5:0];
      end
   end

   assign prdata = reg_hit ? {26'd0, rate_ff} : 32'd0;

   // ---------------------------------------------------------- pipeline
   logic               link_valid [0:NC];
   logic               link_ready [0:NC];
   tcau_pkg::pipe_type link_data  [0:NC];
   logic               front_ready;

   assign req_stall = !front_ready;

   // convert and combine both timecodes into seconds + frames
   tcau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .rate_cfg (rate_ff),
      .up_valid (req_valid),
      .up_ready (front_ready),
      .up_data  (req_data),
      .dn_valid (link_valid[0]),
      .dn_ready (link_ready[0]),
      .dn_data  (link_data[0])
   );

   // row of divide cells; phase boundaries remap the working fields
   for (genvar i = 0; i < NC; i++) begin : g_cell
      tcau_pkg::pipe_type cell_in;

      always_comb begin
         cell_in = link_data[i];
         if (i == K1) begin
            // seconds now reduced modulo the wrap: keep for the total
            cell_in.tot_sec = link_data[i].rem;
            cell_in.quo     = '0;
         end else if (i == K1 + K2) begin
            // seconds field done; divide the minutes next
            cell_in.sec = link_data[i].rem[5:0];
            cell_in.rem = SW'(link_data[i].quo);
            cell_in.quo = '0;
         end
      end

      tcau_cell #(
         .DIV (tcau_pkg::cell_div(i, K1, K2, NC, WS))
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[i]),
         .up_ready (link_ready[i]),
         .up_data  (cell_in),
         .dn_valid (link_valid[i+1]),
         .dn_ready (link_ready[i+1]),
         .dn_data  (link_data[i+1])
      );
   end

   // rebuild the frame count and hold the result for the consumer
   tcau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (link_valid[NC]),
      .up_ready  (link_ready[NC]),
      .up_data   (link_data[NC]),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/tcau_front.sv]
// ----------------------------------------------------------------------------
// Timecode arithmetic front end
// Convert both timecodes to seconds plus frames, then add or subtract.
// ----------------------------------------------------------------------------
module tcau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [5:0]        rate_cfg,
   input  logic              up_valid,
   output logic              up_ready,
   input  tcau_pkg::req_type up_data,
   output logic              dn_valid,
   input  logic              dn_ready,
   output tcau_pkg::pipe_type dn_data
);

   localparam int SW = tcau_pkg::SEC_W;

   logic             a_valid_ff;
   logic [SW-1:0]    sa_ff, sb_ff, sa_in, sb_in;
   logic [5:0]       fa_ff, fb_ff, fa_in, fb_in;
   logic [5:0]       rate_ff, rate_in;
   logic             cmd_ff;
   logic             a_ready;

   logic               b_valid_ff;
   tcau_pkg::pipe_type b_ff, b_in;

   logic [6:0]    fsum;
   logic          carry, borrow, neg;

   assign a_ready  = !a_valid_ff || !b_valid_ff || dn_ready;
   assign up_ready = !a_valid_ff || a_ready && (!b_valid_ff || dn_ready);

   always_comb begin
      rate_in = (rate_cfg == 6'd0) ? 6'd1 : rate_cfg;
      sa_in = SW'((SW'(up_data.first_hours) * SW'(tcau_pkg::BASE_60)
                 + SW'(up_data.first_minutes)) * SW'(tcau_pkg::BASE_60)
                 + SW'(up_data.first_seconds));
      sb_in = SW'((SW'(up_data.second_hours) * SW'(tcau_pkg::BASE_60)
                 + SW'(up_data.second_minutes)) * SW'(tcau_pkg::BASE_60)
                 + SW'(up_data.second_seconds));
      fa_in = (up_data.first_frames >= rate_in) ? 6'd0 : up_data.first_frames;
      fb_in = (up_data.second_frames >= rate_in) ? 6'd0 : up_data.second_frames;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (up_ready) begin
         a_valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         sa_ff   <= sa_in;
         sb_ff   <= sb_in;
         fa_ff   <= fa_in;
         fb_ff   <= fb_in;
         rate_ff <= rate_in;
         cmd_ff  <= up_data.command;
      end
   end

   always_comb begin
      fsum   = 7'(fa_ff) + 7'(fb_ff);
      carry  = fsum >= 7'(rate_ff);
      borrow = fb_ff < fa_ff;
      neg    = (sb_ff < sa_ff) || (sb_ff == sa_ff && borrow);
      b_in         = '0;
      b_in.rate    = rate_ff;
      if (cmd_ff == tcau_pkg::CMD_SUM) begin
         b_in.frm = carry ? 6'(fsum - 7'(rate_ff)) : 6'(fsum);
         b_in.rem = sa_ff + sb_ff + SW'(carry);
      end else if (!neg) begin
         b_in.frm = borrow ? 6'(7'(fb_ff) + 7'(rate_ff) - 7'(fa_ff)) : fb_ff - fa_ff;
         b_in.rem = sb_ff - sa_ff - SW'(borrow);
      end else begin
         b_in.under = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (!b_valid_ff || dn_ready) begin
         b_valid_ff <= a_valid_ff;
      end
      if ((!b_valid_ff || dn_ready) && a_valid_ff) begin
         b_ff <= b_in;
      end
   end

   assign dn_valid = b_valid_ff;
   assign dn_data  = b_ff;

endmodule

[rtl/tcau_cell.sv]
// ----------------------------------------------------------------------------
// Timecode arithmetic chain cell
// One compare-and-subtract step of a restoring divide, one register stage.
// ----------------------------------------------------------------------------
module tcau_cell #(
   parameter int unsigned DIV = 60
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  tcau_pkg::pipe_type up_data,
   output logic               dn_valid,
   input  logic               dn_ready,
   output tcau_pkg::pipe_type dn_data
);

   localparam int SW = tcau_pkg::SEC_W;
   localparam int QW = tcau_pkg::QUO_W;

   logic               valid_ff;
   tcau_pkg::pipe_type data_ff, data_in;
   logic               fit;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      fit         = 32'(up_data.rem) >= DIV;
      data_in     = up_data;
      data_in.rem = fit ? up_data.rem - SW'(DIV) : up_data.rem;
      data_in.quo = {up_data.quo[QW-2:0], fit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

[rtl/tcau_back.sv]
// ----------------------------------------------------------------------------
// Timecode arithmetic output stage
// Rebuild the total frame count and hold the result transaction.
// ----------------------------------------------------------------------------
module tcau_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  tcau_pkg::pipe_type up_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tcau_pkg::rsp_type  rsp_data
);

   localparam int TW = tcau_pkg::TOTAL_W;

   logic              valid_ff;
   tcau_pkg::rsp_type data_ff, data_in;

   assign up_ready = !valid_ff || !rsp_stall;

   always_comb begin
      data_in.result_hours   = up_data.quo[6:0];
      data_in.result_minutes = up_data.rem[5:0];
      data_in.result_seconds = up_data.sec;
      data_in.result_frames  = up_data.frm;
      data_in.result_total   = TW'(TW'(up_data.tot_sec) * TW'(up_data.rate)
                                   + TW'(up_data.frm));
      data_in.underflow      = up_data.under;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

[rtl/tcau_checker.sv]
// ----------------------------------------------------------------------------
// Timecode arithmetic unit checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "timecode_arithmetic_unit_top_macros.svh"

module tcau_checker #(
   parameter int HOUR_WRAP = tcau_pkg::HOUR_WRAP_DEFAULT
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tcau_pkg::rsp_type rsp_data
);

   `TCAU_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result after reset")
   `TCAU_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped")
   `TCAU_ASSERT_IMPL(a_under_zero, clock, reset, rsp_valid && rsp_data.underflow, rsp_data.result_total == '0 && rsp_data.result_hours == '0, "underflow nonzero")
   `TCAU_ASSERT_IMPL(a_fields_range, clock, reset, rsp_valid, rsp_data.result_minutes < 6'd60 && rsp_data.result_seconds < 6'd60 && rsp_data.result_hours < 7'(HOUR_WRAP), "field out of range")

endmodule

bind timecode_arithmetic_unit_top tcau_checker #(
   .HOUR_WRAP (HOUR_WRAP)
) u_tcau_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/timecode_arithmetic_unit_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timecode arithmetic unit testbench
// Drives sum and duration transactions at several frame rates, predicts each
// result from the two frame counts and checks every result field in order.
// ----------------------------------------------------------------------------

// Holds the timecode results still owed by the block, oldest first.
class timecode_scoreboard;
   tcau_pkg::rsp_type owed_results[$];
   int unsigned       mismatches;
   int unsigned       checked;

   // Compute the expected result of one accepted transaction.
   function void note_request(tcau_pkg::req_type rq, int unsigned rate_reg);
      longint unsigned rate, wrap, a, b, tot, secs, mins;
      tcau_pkg::rsp_type rs;
      rate = (rate_reg % 64 == 0) ? 1 : rate_reg % 64;
      wrap = 64'd100 * 3600 * rate;
      a = ((rq.first_hours * 64'd60 + rq.first_minutes) * 60 + rq.first_seconds) * rate
          + ((rq.first_frames >= rate) ? 0 : rq.first_frames);
      b = ((rq.second_hours * 64'd60 + rq.second_minutes) * 60 + rq.second_seconds) * rate
          + ((rq.second_frames >= rate) ? 0 : rq.second_frames);
      rs.underflow = 1'b0;
      if (rq.command == tcau_pkg::CMD_SUM) begin
         tot = (a + b) % wrap;
      end else if (b < a) begin
         tot = 0;
         rs.underflow = 1'b1;
      end else begin
         tot = (b - a) % wrap;
      end
      secs = tot / rate;
      mins = secs / 60;
      rs.result_hours   = 7'(mins / 60);
      rs.result_minutes = 6'(mins % 60);
      rs.result_seconds = 6'(secs % 60);
      rs.result_frames  = 6'(tot % rate);
      rs.result_total   = 25'(tot);
      owed_results.push_back(rs);
   endfunction

   task report(string what, longint unsigned got, longint unsigned want);
      mismatches++;
      $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
   endtask

   task check_result(tcau_pkg::rsp_type rs);
      tcau_pkg::rsp_type ex;
      if (owed_results.size() == 0) begin
         report("unexpected result", 1, 0);
         return;
      end
      ex = owed_results.pop_front();
      if (rs.result_hours != ex.result_hours)
         report("hours", rs.result_hours, ex.result_hours);
      if (rs.result_minutes != ex.result_minutes)
         report("minutes", rs.result_minutes, ex.result_minutes);
      if (rs.result_seconds != ex.result_seconds)
         report("seconds", rs.result_seconds, ex.result_seconds);
      if (rs.result_frames != ex.result_frames)
         report("frames", rs.result_frames, ex.result_frames);
      if (rs.result_total != ex.result_total)
         report("total", rs.result_total, ex.result_total);
      if (rs.underflow != ex.underflow)
         report("underflow", rs.underflow, ex.underflow);
      checked++;
   endtask
endclass

module timecode_arithmetic_unit_top_tb;

   localparam int LATENCY   = 25;
   localparam int WDOG_MAX  = 5000;
   localparam int REQ_W     = $bits(tcau_pkg::req_type);

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   tcau_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   tcau_pkg::rsp_type rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [2:0]        paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   timecode_scoreboard board = new();
   int unsigned frame_rate_now = tcau_pkg::RATE_RESET;
   // idle odds in percent for each side, changed per phase
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   bit          hold_off = 1'b0;
   int unsigned sent = 0;
   int unsigned wdog = 0;

   timecode_arithmetic_unit_top DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Score both channels at the edge where the handshake completes.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_data, frame_rate_now);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
      end
   end

   // Drive the receiver stall: random odds, or a long hold-off when asked.
   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Watchdog: count cycles without any accepted transaction, reset or APB access.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || psel)
         wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
         $display("watchdog expired, %0d results owed", board.owed_results.size());
         $display("timecode_arithmetic_unit_top_tb: errors");
         $finish;
      end
   end

   // Offer one transaction and hold it until it is accepted; the next call
   // replaces it or drops valid while idling, and drain() drops valid.
   task automatic send_request(tcau_pkg::req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.owed_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // APB write, setup then access phase; only while the pipeline is empty.
   task automatic write_frame_rate(logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= 3'(4 * tcau_pkg::REG_FRAME_RATE);
      pwdata  <= value;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      frame_rate_now = value & 32'h3f;
   endtask

   function automatic tcau_pkg::req_type make_request(bit legal);
      tcau_pkg::req_type rq;
      int unsigned       top_frame;
      top_frame = frame_rate_now > 0 ? frame_rate_now - 1 : 0;
      rq = tcau_pkg::req_type'(REQ_W'({$urandom, $urandom}));
      if (legal) begin
         rq.first_hours    = 7'($urandom_range(99));
         rq.first_minutes  = 6'($urandom_range(59));
         rq.first_seconds  = 6'($urandom_range(59));
         rq.first_frames   = 6'($urandom_range(top_frame));
         rq.second_hours   = 7'($urandom_range(99));
         rq.second_minutes = 6'($urandom_range(59));
         rq.second_seconds = 6'($urandom_range(59));
         rq.second_frames  = 6'($urandom_range(top_frame));
         // keep many durations close so small positives and zero show up
         if ($urandom_range(3) == 0) begin
            rq.second_hours   = rq.first_hours;
            rq.second_minutes = rq.first_minutes;
         end
      end
      return rq;
   endfunction

   task automatic directed_set();
      tcau_pkg::req_type rq;
      rq = '0;
      send_request(rq);                       // zero plus zero
      rq.command = tcau_pkg::CMD_DURATION;
      send_request(rq);                       // zero duration, no underflow
      rq = '1;
      rq.command = tcau_pkg::CMD_SUM;
      send_request(rq);                       // every field at its top value
      rq.command = tcau_pkg::CMD_DURATION;
      send_request(rq);
      rq = '0;
      rq.first_hours = 7'd99; rq.first_minutes = 6'd59; rq.first_seconds = 6'd59;
      rq.first_frames = 6'(frame_rate_now - 1);
      rq.second_frames = 6'd1;
      send_request(rq);                       // sum wraps at the hour limit
      rq.command = tcau_pkg::CMD_DURATION;
      send_request(rq);                       // negative duration clamps
      rq.first_frames = 6'(frame_rate_now);   // frames at rate read as zero
      rq.second_frames = 6'd63;
      send_request(rq);
      rq = '0;
      rq.command = tcau_pkg::CMD_DURATION;
      rq.second_hours = 7'd99; rq.second_minutes = 6'd59; rq.second_seconds = 6'd59;
      rq.second_frames = 6'(frame_rate_now - 1);
      send_request(rq);                       // largest positive duration
      rq.first_minutes = 6'd63; rq.first_seconds = 6'd63; rq.second_hours = 7'd127;
      send_request(rq);                       // out-of-range positional fields
   endtask

   task automatic random_run(int unsigned count);
      repeat (count) send_request(make_request($urandom_range(9) < 8));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset rate first, then extremes and odd rates
      directed_set();
      drain();
      write_frame_rate(1);  directed_set(); drain();
      write_frame_rate(60); directed_set(); drain();
      write_frame_rate(0);  directed_set(); drain();
      write_frame_rate(63); directed_set(); drain();

      write_frame_rate(30);
      send_idle_pct = 29; recv_idle_pct = 84;
      random_run(300);
      drain();

      write_frame_rate(24);
      send_idle_pct = 84; recv_idle_pct = 29;
      random_run(250);
      drain();

      // hold the receiver off long enough to fill the pipeline
      write_frame_rate(60);
      send_idle_pct = 0; recv_idle_pct = 0;
      fork
         begin
            hold_off = 1'b1;
            repeat (120) @(posedge clock);
            hold_off = 1'b0;
         end
         random_run(150);
      join
      // pause the sender until everything owed has come back
      drain();

      write_frame_rate($urandom_range(60, 1));
      random_run(200);
      drain();

      $display("covered %0d transactions over rates 0, 1, 24, 25, 30, 60, 63 and random", sent);
      $display("checked %0d results, %0d mismatches", board.checked, board.mismatches);
      if (board.mismatches == 0 && board.owed_results.size() == 0) begin
         $display("timecode_arithmetic_unit_top_tb: clean");
      end else begin
         $display("timecode_arithmetic_unit_top_tb: errors");
      end
      $finish;
   end
endmodule

[filelist.f]
+incdir+rtl
rtl/tcau_pkg.sv
rtl/tcau_front.sv
rtl/tcau_cell.sv
rtl/tcau_back.sv
rtl/timecode_arithmetic_unit_top.sv
rtl/tcau_checker.sv
tb/timecode_arithmetic_unit_top_tb.sv
